>>> src/sdd_pkg.sv
// ----------------------------------------------------------------------------
// sdd_pkg
// shared types and constants of the signed decimal display command block
// ----------------------------------------------------------------------------
package sdd_pkg;

    localparam int MAG_WIDTH  = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BIT_CNT_W  = $clog2(MAG_WIDTH);
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
    localparam int COUNT_W    = $clog2(NUM_DIGITS + 2);

    localparam logic [3:0] SCAN_LIMIT_ADDR = 4'hB;
    localparam logic [3:0] NOP_ADDR        = 4'h0;
    localparam logic [7:0] MINUS_CODE_RESET = 8'd10;

    typedef logic [3:0] bcd_digit_t;
    typedef bcd_digit_t [NUM_DIGITS-1:0] sdd_digits_t;

    // converter to command sequencer
    typedef struct packed {
        logic start;
        logic negative;
    } sdd_ctrl_t;

    // command sequencer back to converter
    typedef struct packed {
        logic idle;
    } sdd_status_t;

endpackage

>>> src/signed_decimal_to_display_commands.sv
// ----------------------------------------------------------------------------
// signed_decimal_to_display_commands
// signed number to seven-segment display driver register writes
// ----------------------------------------------------------------------------
// Takes one signed 32-bit number per input word and produces the register
// writes (address, data) that show it on a code-B display driver. The
// magnitude is converted to decimal by a row of ten digit cells, one bit
// shifted in per cycle (shift-and-add-3). The command sequencer then issues,
// in order: the minus code at position count+1 for a negative number, the
// scan limit (address 11) if it differs from the last one written, and the
// digits 1..count, least significant first. A number needing more than
// DIGIT_POSITIONS positions gives a single overflow word instead. A number
// passes through acceptance, the conversion chain and a handover, then the
// writes go out one per cycle while the output is not stalled (an unchanged
// scan limit still passes through its state, with no write). A new number
// is accepted once the previous one's final write has been loaded into the
// output register, so conversion overlaps a pending final word. The minus
// code register is written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module signed_decimal_to_display_commands #(
    parameter int DIGIT_POSITIONS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  minus_code,
    // number input channel
    input  logic        number_valid,
    output logic        number_ready,
    input  logic signed [31:0] number_value,
    // register write output channel
    output logic        result_valid,
    input  logic        result_ready,
    output logic [3:0]  reg_address,
    output logic [7:0]  reg_data,
    output logic        last_write,
    output logic        overflow
);
    import sdd_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE,
        T_CONV,
        T_HAND
    } conv_state_t;

    conv_state_t          state_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [MAG_WIDTH-1:0] mag_reg;
    logic                 negative_reg;
    logic [7:0]           minus_code_reg;

    logic [MAG_WIDTH-1:0] raw;
    logic [MAG_WIDTH-1:0] mag_next;
    logic                 accept;
    logic                 shift_en;
    logic [NUM_DIGITS:0]  carry;
    sdd_digits_t          digits;
    sdd_ctrl_t            ctrl;
    sdd_status_t          status;

    // accept only when both the converter and the sequencer are free
    assign number_ready = (state_reg == T_IDLE) && status.idle;
    assign accept       = number_valid && number_ready;
    assign cfg_ready    = 1'b1;

    // magnitude as unsigned, most negative value gives 2^31
    assign raw      = MAG_WIDTH'(number_value);
    assign mag_next = raw[MAG_WIDTH-1] ? (~raw + MAG_WIDTH'(1)) : raw;
    assign shift_en = (state_reg == T_CONV);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            bit_cnt_reg    <= '0;
            minus_code_reg <= MINUS_CODE_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                minus_code_reg <= minus_code;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (accept)
                    begin
                        bit_cnt_reg <= '0;
                        state_reg   <= T_CONV;
                    end
                end
                T_CONV:
                begin
                    bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
                    if (bit_cnt_reg == BIT_CNT_W'(MAG_WIDTH - 1))
                    begin
                        state_reg <= T_HAND;
                    end
                end
                T_HAND:
                begin
                    state_reg <= T_IDLE;
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    // magnitude shifter feeding the digit chain, msb first
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg      <= mag_next;
            negative_reg <= raw[MAG_WIDTH-1];
        end
        else if (shift_en)
        begin
            mag_reg <= {mag_reg[MAG_WIDTH-2:0], 1'b0};
        end
    end

    // chain of digit cells, least significant digit takes the new bit
    assign carry[0] = mag_reg[MAG_WIDTH-1];

    for (genvar g = 0; g < NUM_DIGITS; g++)
    begin : g_cell
        sdd_bcd_cell u_cell (
            .clk       (clk),
            .clear     (accept),
            .shift_en  (shift_en),
            .shift_in  (carry[g]),
            .shift_out (carry[g+1]),
            .digit     (digits[g])
        );
    end

    // digits are final in the handover cycle
    assign ctrl.start    = (state_reg == T_HAND);
    assign ctrl.negative = negative_reg;

    sdd_cmd_seq #(
        .DIGIT_POSITIONS (DIGIT_POSITIONS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .digits       (digits),
        .minus_code   (minus_code_reg),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .reg_address  (reg_address),
        .reg_data     (reg_data),
        .last_write   (last_write),
        .overflow     (overflow)
    );

    // overflow word is a lone no-op write that ends the number
    a_ovf_last : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && overflow |-> last_write && (reg_address == NOP_ADDR)
                                     && (reg_data == 8'd0))
        else $error("overflow word malformed");

    // scan limit data fits the three-bit register
    a_scan_data : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (reg_address == SCAN_LIMIT_ADDR) |-> (reg_data[7:3] == 5'd0))
        else $error("scan limit data out of range");

    // digit and minus writes land on existing positions
    a_pos_range : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !overflow && (reg_address != SCAN_LIMIT_ADDR)
            |-> (reg_address >= 4'd1) && (reg_address <= 4'(DIGIT_POSITIONS)))
        else $error("write to missing digit position");

    // one number at a time through the conversion chain
    a_busy : assert property (@(posedge clk) disable iff (!rst_n)
        number_valid && number_ready |=> !number_ready)
        else $error("input accepted during conversion");

endmodule

>>> src/sdd_bcd_cell.sv
// ----------------------------------------------------------------------------
// sdd_bcd_cell
// one decimal digit of the shift-and-add-3 conversion chain
// ----------------------------------------------------------------------------
module sdd_bcd_cell (
    input  logic                clk,
    input  logic                clear,
    input  logic                shift_en,
    input  logic                shift_in,
    output logic                shift_out,
    output sdd_pkg::bcd_digit_t digit
);
    import sdd_pkg::*;

    bcd_digit_t digit_reg;
    bcd_digit_t digit_next;
    bcd_digit_t adjusted;

    // add 3 when the digit would pass 9 after doubling
    always_comb
    begin
        adjusted = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
        if (clear)
        begin
            digit_next = '0;
        end
        else if (shift_en)
        begin
            digit_next = {adjusted[2:0], shift_in};
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign shift_out = adjusted[3];
    assign digit     = digit_reg;

endmodule

>>> src/sdd_cmd_seq.sv
// ----------------------------------------------------------------------------
// sdd_cmd_seq
// turns the converted digits into display driver register writes
// ----------------------------------------------------------------------------
module sdd_cmd_seq #(
    parameter int DIGIT_POSITIONS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sdd_pkg::sdd_ctrl_t   ctrl,
    input  sdd_pkg::sdd_digits_t digits,
    input  logic [7:0]          minus_code,
    output sdd_pkg::sdd_status_t status,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [3:0]          reg_address,
    output logic [7:0]          reg_data,
    output logic                last_write,
    output logic                overflow
);
    import sdd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OVF,
        S_MINUS,
        S_SCAN,
        S_DIGIT
    } seq_state_t;

    seq_state_t           state_reg;
    logic                 negative_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [DIGIT_IDX_W-1:0] idx_reg;
    logic [2:0]           shown_limit_reg;
    logic                 result_valid_reg;
    logic [3:0]           reg_address_reg;
    logic [7:0]           reg_data_reg;
    logic                 last_write_reg;
    logic                 overflow_reg;

    logic [COUNT_W-1:0]   count_next;
    logic [COUNT_W-1:0]   needed;
    logic [2:0]           limit;
    logic                 out_free;
    logic                 word_load;

    // number of significant digits, at least one
    always_comb
    begin
        count_next = COUNT_W'(1);
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (digits[i] != 4'd0)
            begin
                count_next = COUNT_W'(i + 1);
            end
        end
        needed = count_next + COUNT_W'(ctrl.negative);
    end

    assign limit    = negative_reg ? count_reg[2:0] : 3'(count_reg - COUNT_W'(1));
    assign out_free = !result_valid_reg || result_ready;

    // a new word goes into the output register this cycle
    assign word_load = out_free
                       && ((state_reg inside {S_OVF, S_MINUS, S_DIGIT})
                           || ((state_reg == S_SCAN) && (limit != shown_limit_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            shown_limit_reg  <= '0;
            result_valid_reg <= 1'b0;
            negative_reg     <= 1'b0;
            count_reg        <= '0;
            idx_reg          <= '0;
            reg_address_reg  <= '0;
            reg_data_reg     <= '0;
            last_write_reg   <= 1'b0;
            overflow_reg     <= 1'b0;
        end
        else
        begin
            if (result_valid_reg && result_ready && !word_load)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        negative_reg <= ctrl.negative;
                        count_reg    <= count_next;
                        idx_reg      <= '0;
                        if (needed > COUNT_W'(DIGIT_POSITIONS))
                        begin
                            state_reg <= S_OVF;
                        end
                        else if (ctrl.negative)
                        begin
                            state_reg <= S_MINUS;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_OVF:
                begin
                    if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        reg_address_reg  <= NOP_ADDR;
                        reg_data_reg     <= '0;
                        last_write_reg   <= 1'b1;
                        overflow_reg     <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                S_MINUS:
                begin
                    if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        reg_address_reg  <= 4'(count_reg + COUNT_W'(1));
                        reg_data_reg     <= minus_code;
                        last_write_reg   <= 1'b0;
                        overflow_reg     <= 1'b0;
                        state_reg        <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (limit == shown_limit_reg)
                    begin
                        state_reg <= S_DIGIT;
                    end
                    else if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        reg_address_reg  <= SCAN_LIMIT_ADDR;
                        reg_data_reg     <= {5'd0, limit};
                        last_write_reg   <= 1'b0;
                        overflow_reg     <= 1'b0;
                        shown_limit_reg  <= limit;
                        state_reg        <= S_DIGIT;
                    end
                end
                S_DIGIT:
                begin
                    if (out_free)
                    begin
                        result_valid_reg <= 1'b1;
                        reg_address_reg  <= 4'(idx_reg) + 4'd1;
                        reg_data_reg     <= {4'd0, digits[idx_reg]};
                        overflow_reg     <= 1'b0;
                        idx_reg          <= idx_reg + DIGIT_IDX_W'(1);
                        if (COUNT_W'(idx_reg) + COUNT_W'(1) == count_reg)
                        begin
                            last_write_reg <= 1'b1;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            last_write_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign status.idle  = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign reg_address  = reg_address_reg;
    assign reg_data     = reg_data_reg;
    assign last_write   = last_write_reg;
    assign overflow     = overflow_reg;

endmodule

>>> tb/display_write_checker.sv
// ----------------------------------------------------------------------------
// display_write_checker
// watches the number, cfg and register write channels and checks every word
// ----------------------------------------------------------------------------
// Keeps its own copy of the minus code and of the scan limit last sent to the
// driver. Every accepted number is turned into the register writes it should
// cause, and those are held in order. Every accepted output word is compared
// with the oldest one held. Mismatches and unexpected words are counted.
// ----------------------------------------------------------------------------
module display_write_checker #(
    parameter int DIGIT_POSITIONS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  minus_code,
    input  logic        number_valid,
    input  logic        number_ready,
    input  logic [31:0] number_value,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [3:0]  reg_address,
    input  logic [7:0]  reg_data,
    input  logic        last_write,
    input  logic        overflow,
    output int          mismatch_count,
    output int          writes_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import sdd_pkg::*;

    typedef struct packed {
        logic [3:0] address;
        logic [7:0] data;
        logic       is_last;
        logic       is_overflow;
    } drv_write_t;

    logic [7:0] minus_byte;
    logic [2:0] shown_limit;
    drv_write_t pending_writes [$];

    function automatic drv_write_t drv_word(
        input logic [3:0] address,
        input logic [7:0] data,
        input logic       is_last,
        input logic       is_overflow
    );
        drv_write_t w;
        w.address     = address;
        w.data        = data;
        w.is_last     = is_last;
        w.is_overflow = is_overflow;
        return w;
    endfunction

    // queue the register writes one number should cause
    function automatic void predict_display_writes(input logic [31:0] raw);
        logic        negative;
        logic [31:0] mag;
        logic [3:0]  digit [NUM_DIGITS];
        int          count;
        logic [2:0]  limit;
        negative = raw[31];
        mag = negative ? 32'd0 - raw : raw;
        count = 0;
        do
        begin
            digit[count] = 4'(mag % 10);
            mag = mag / 10;
            count++;
        end
        while (mag != 0 && count < NUM_DIGITS);

        // too wide for the display: one no-op word, scan limit untouched
        if (count + int'(negative) > DIGIT_POSITIONS)
        begin
            pending_writes.push_back(drv_word(NOP_ADDR, 8'd0, 1'b1, 1'b1));
            return;
        end

        if (negative)
        begin
            pending_writes.push_back(drv_word(4'(count + 1), minus_byte, 1'b0, 1'b0));
            limit = 3'(count);
        end
        else
            limit = 3'(count - 1);

        if (limit != shown_limit)
        begin
            pending_writes.push_back(drv_word(SCAN_LIMIT_ADDR, 8'(limit), 1'b0, 1'b0));
            shown_limit = limit;
        end

        for (int i = 0; i < count; i++)
            pending_writes.push_back(drv_word(4'(i + 1), 8'(digit[i]), i == count - 1, 1'b0));
    endfunction

    initial
    begin
        mismatch_count     = 0;
        writes_outstanding = 0;
        minus_byte         = MINUS_CODE_RESET;
        shown_limit        = '0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        drv_write_t got;
        drv_write_t want;
        if (!rst_n)
        begin
            minus_byte  = MINUS_CODE_RESET;
            shown_limit = '0;
            pending_writes.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                minus_byte = minus_code;

            if (result_valid && result_ready)
            begin
                got = drv_word(reg_address, reg_data, last_write, overflow);
                if (pending_writes.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected word addr=%0d data=%0d last=%0b ovf=%0b",
                             $time, got.address, got.data, got.is_last, got.is_overflow);
                end
                else
                begin
                    want = pending_writes.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        // address, data, last, overflow
                        $display("%0t: expected %0d,%0d,%0b,%0b got %0d,%0d,%0b,%0b",
                                 $time, want.address, want.data, want.is_last,
                                 want.is_overflow, got.address, got.data,
                                 got.is_last, got.is_overflow);
                    end
                end
            end

            if (number_valid && number_ready)
                predict_display_writes(number_value);
        end
        writes_outstanding = pending_writes.size();
    end

endmodule

>>> tb/signed_decimal_to_display_commands_tb.sv
// ----------------------------------------------------------------------------
// signed_decimal_to_display_commands_tb
// stimulus and verdict for the signed number to display command block
// ----------------------------------------------------------------------------
// Sends a directed set of numbers (zero, sign edges, widest values that still
// fit, first values that overflow, repeated and changing scan limits), then
// random numbers in four phases with different minus codes and different
// amounts of idling on both sides. One phase holds the receiver off for a
// long stretch so that the block backs up onto its input. A checker beside
// the block predicts and compares every word.
// ----------------------------------------------------------------------------
module signed_decimal_to_display_commands_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGIT_POSITIONS = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 100;
    localparam int PHASE_NUMBERS   = 52;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [7:0]         minus_code   = 8'd0;
    logic               number_valid = 1'b0;
    logic               number_ready;
    logic signed [31:0] number_value = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [3:0]         reg_address;
    logic [7:0]         reg_data;
    logic               last_write;
    logic               overflow;

    int mismatch_count;
    int writes_outstanding;

    // idling controls, percent of cycles
    int   send_gap_pct = 0;
    int   stall_pct    = 0;
    logic holding_off  = 1'b0;
    event hold_off_start;

    // sign edges, widest numbers that fit, first ones that do not,
    // scan limit kept, shrunk and grown
    int directed_numbers [$] = '{
        0, 1, -1, 9, 10, -10, 99, -99999,
        1234567, -1234567, 99999999, 12345678, 100000000,
        -9999999, -10000000, 2147483647, int'(32'h8000_0000),
        5, 0, -5, -7, 7, 24
    };

    always #1 clk = ~clk;

    signed_decimal_to_display_commands #(
        .DIGIT_POSITIONS(DIGIT_POSITIONS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .minus_code   (minus_code),
        .number_valid (number_valid),
        .number_ready (number_ready),
        .number_value (number_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .reg_address  (reg_address),
        .reg_data     (reg_data),
        .last_write   (last_write),
        .overflow     (overflow)
    );

    display_write_checker #(
        .DIGIT_POSITIONS(DIGIT_POSITIONS)
    ) checker_i (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .minus_code         (minus_code),
        .number_valid       (number_valid),
        .number_ready       (number_ready),
        .number_value       (number_value),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .reg_address        (reg_address),
        .reg_data           (reg_data),
        .last_write         (last_write),
        .overflow           (overflow),
        .mismatch_count     (mismatch_count),
        .writes_outstanding (writes_outstanding)
    );

    // receiver: random stalls, or a solid hold-off when asked for
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (holding_off)
            result_ready <= 1'b0;
        else
            result_ready <= ($urandom_range(99) >= stall_pct);
    end

    // long receiver hold-off, counted here so the sender carries on meanwhile
    initial
    begin
        forever
        begin
            @(hold_off_start);
            holding_off <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            holding_off <= 1'b0;
        end
    end

    // mostly numbers that fit, spread over all digit counts, some full-width
    // noise so the top bits get exercised too
    function automatic logic [31:0] random_number();
        int unsigned n;
        int unsigned span;
        int unsigned mag;
        if ($urandom_range(99) < 15)
            return $urandom;
        n = $urandom_range(9, 1);
        span = 1;
        repeat (n) span = span * 10;
        mag = $urandom_range(span - 1, 0);
        if ($urandom_range(1, 0) == 1)
            return 32'd0 - mag;
        return mag;
    endfunction

    // offer one number, returns on the edge it is taken
    task automatic send_number(input logic [31:0] value);
        while ($urandom_range(99) < send_gap_pct)
        begin
            number_valid <= 1'b0;
            @(posedge clk);
        end
        number_valid <= 1'b1;
        number_value <= value;
        @(posedge clk);
        while (!number_ready) @(posedge clk);
    endtask

    // stop offering and wait for every predicted word to come out
    task automatic settle();
        number_valid <= 1'b0;
        @(posedge clk);
        while (writes_outstanding != 0) @(posedge clk);
    endtask

    task automatic write_minus_code(input logic [7:0] code);
        cfg_valid  <= 1'b1;
        minus_code <= code;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int gap_pct, input int stall);
        send_gap_pct = gap_pct;
        stall_pct   <= stall;
        repeat (PHASE_NUMBERS) send_number(random_number());
        settle();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed numbers with the reset minus code, no idling
        foreach (directed_numbers[i])
            send_number(directed_numbers[i]);
        settle();

        // lowest minus code, flat out
        write_minus_code(8'h00);
        run_phase(0, 0);

        // highest minus code, sender idling
        write_minus_code(8'hFF);
        run_phase(55, 0);

        // receiver stalling, starting with a long hold-off to back the block up
        write_minus_code(8'($urandom_range(254, 1)));
        -> hold_off_start;
        run_phase(0, 55);

        // both sides idling
        write_minus_code(8'($urandom_range(255, 0)));
        run_phase(27, 27);

        // give any stray word time to show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && writes_outstanding == 0)
            $display("signed_decimal_to_display_commands_tb OK");
        else
            $display("signed_decimal_to_display_commands_tb NOT OK");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #1_000_000;
        $display("signed_decimal_to_display_commands_tb NOT OK");
        $finish;
    end

endmodule
